// File: rtl/core/kspm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_pkg: shared types and codes of the key sequence prefix matcher
// Request and result payloads, the queued command format, op and kind codes.
// ----------------------------------------------------------------------------
package kspm_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	localparam logic KIND_BINDING = 1'b0;
	localparam logic KIND_RAW     = 1'b1;

	// entry_bytes field width; sequence bytes past it are zero
	localparam int FIELD_BYTES = 4;

	typedef struct packed {
		logic        op;
		logic [6:0]  entry_slot;
		logic [2:0]  entry_length;
		logic [31:0] entry_bytes;
		logic [7:0]  key_byte;
	} kspm_in_t;

	typedef struct packed {
		logic       kind;
		logic [6:0] binding_slot;
		logic [7:0] raw_byte;
		logic       last;
	} kspm_out_t;

	// classified request as it sits in the queue
	typedef struct packed {
		logic        is_key;
		logic [6:0]  slot;
		logic [2:0]  len;    // already clamped
		logic [31:0] bytes;
		logic [7:0]  key;
	} kspm_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/key_sequence_prefix_matcher.sv
`default_nettype none
// Loads: a load is queued, then written to the table when the back end pops it.
//   Key bytes: the back end scans the table slot by slot from slot 0 and
//   strobes a binding at the first exact match; raw results follow the end of
//   the scan, one per cycle. One slot per cycle is read over the table RAM read
//   port; the back end pops the next queued command only once it is idle again.
// Reset: after arst_n is released the table is cleared slot by slot, and
//   busy stays high meanwhile. Results are strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// key_sequence_prefix_matcher: keyboard escape sequence matcher
// Gathers key bytes, reports the first exactly matching table slot, waits on
// a proper prefix, and otherwise passes the gathered bytes through raw.
// ----------------------------------------------------------------------------
module key_sequence_prefix_matcher #(
	parameter int TABLE_SLOTS   = 128,
	parameter int MAX_SEQ_BYTES = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request side: accepted when start is high and busy is low
	input  wire logic                start,
	input  wire kspm_pkg::kspm_in_t  item,
	output logic                     busy,
	// result side: one strobe per result, no back pressure
	output logic                     strobe,
	output kspm_pkg::kspm_out_t      result
);
	import kspm_pkg::*;

	kspm_cmd_t head;
	logic      head_valid;
	logic      pop;
	logic      clearing;

	// front: classifies requests, drops out-of-range loads, queues commands
	kspm_front #(
		.TABLE_SLOTS   (TABLE_SLOTS),
		.MAX_SEQ_BYTES (MAX_SEQ_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.hold       (clearing),
		.busy       (busy),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// back: table RAM, per-byte slot scan, binding or raw byte sequencing
	kspm_back #(
		.TABLE_SLOTS   (TABLE_SLOTS),
		.MAX_SEQ_BYTES (MAX_SEQ_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.clearing   (clearing),
		.strobe     (strobe),
		.result     (result)
	);

endmodule
`default_nettype wire

// File: rtl/core/kspm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/kspm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_front: request intake, classification and command queue
// Drops loads to missing slots, clamps lengths, queues up to two commands.
// ----------------------------------------------------------------------------
module kspm_front #(
	parameter int TABLE_SLOTS   = 128,
	parameter int MAX_SEQ_BYTES = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire kspm_pkg::kspm_in_t  item,
	input  wire logic                hold,
	output logic                     busy,
	output kspm_pkg::kspm_cmd_t      head,
	output logic                     head_valid,
	input  wire logic                pop
);
	import kspm_pkg::*;

	kspm_cmd_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	kspm_cmd_t  cmd;
	logic       keep;
	logic       push;

	always_comb begin
		cmd.is_key = (item.op == OP_KEY);
		cmd.slot   = item.entry_slot;
		cmd.len    = (int'(item.entry_length) > MAX_SEQ_BYTES) ?
			3'(MAX_SEQ_BYTES) : item.entry_length;
		cmd.bytes  = item.entry_bytes;
		cmd.key    = item.key_byte;
		keep       = cmd.is_key || (int'(item.entry_slot) < TABLE_SLOTS);
	end

	assign busy       = (cnt_q == 2'd2) || hold;
	assign push       = start && !busy && keep;
	assign head       = mem_q[rp_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/kspm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_back: table store, slot scan and result sequencing
// Clears the table after reset, writes loads, scans slots for each key byte.
// ----------------------------------------------------------------------------
module kspm_back #(
	parameter int TABLE_SLOTS   = 128,
	parameter int MAX_SEQ_BYTES = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kspm_pkg::kspm_cmd_t  head,
	input  wire logic                 head_valid,
	output logic                      pop,
	output logic                      clearing,
	output logic                      strobe,
	output kspm_pkg::kspm_out_t       result
);
	import kspm_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int LW = $clog2(MAX_SEQ_BYTES + 1);
	localparam int CW = LW;
	localparam int IW = $clog2(MAX_SEQ_BYTES);
	localparam int EW = MAX_SEQ_BYTES * 8 + LW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] scan_q;
	logic          issue_done_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_slot_s1;
	logic          prefix_q;
	logic [7:0]    gb_q [MAX_SEQ_BYTES];
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] emit_q;
	logic          strobe_q;
	kspm_out_t     result_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [EW-1:0] entry;
	logic [EW-1:0] rdata;
	logic [LW-1:0] rd_len;
	logic [MAX_SEQ_BYTES-1:0] byte_ok;
	logic          hit;
	logic          exact;
	logic          prefix_now;
	logic          emit_last;

	// table entry layout: {bytes, length}
	assign entry[LW-1:0] = LW'(head.len);
	for (genvar i = 0; i < MAX_SEQ_BYTES; i++) begin : g_bytes
		if (i < FIELD_BYTES) begin : g_in
			assign entry[LW + 8*i +: 8] = head.bytes[8*i +: 8];
		end else begin : g_zero
			assign entry[LW + 8*i +: 8] = 8'd0;
		end
	end

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign clearing = (state_q == ST_CLEAR);
	assign we       = clearing || (pop && !head.is_key);
	assign waddr    = clearing ? clr_q : AW'(head.slot);
	assign wdata    = clearing ? '0 : entry;

	kspm_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (scan_q),
		.rdata (rdata)
	);

	// compare the returned slot against the gathered bytes
	always_comb begin
		rd_len = rdata[LW-1:0];
		for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
			byte_ok[i] = (CW'(i) >= cnt_q) || (rdata[LW + 8*i +: 8] == gb_q[i]);
		end
		hit        = (rd_len != '0) && (rd_len >= cnt_q) && (&byte_ok);
		exact      = hit && (rd_len == cnt_q);
		prefix_now = hit && (rd_len != cnt_q);
		emit_last  = ((CW'(emit_q) + CW'(1)) == cnt_q);
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= scan_q;
		if (pop && head.is_key) begin
			gb_q[cnt_q[IW-1:0]] <= head.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			prefix_q     <= 1'b0;
			cnt_q        <= '0;
			emit_q       <= '0;
			strobe_q     <= 1'b0;
			result_q     <= '0;
		end else begin
			// one result per binding, one per cycle while emitting raw bytes
			strobe_q  <= ((state_q == ST_SCAN) && rd_vld_s1 && exact) ||
				(state_q == ST_EMIT);
			rd_vld_s1 <= (state_q == ST_SCAN) && !issue_done_q;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && head.is_key) begin
						cnt_q        <= cnt_q + CW'(1);
						scan_q       <= '0;
						issue_done_q <= 1'b0;
						prefix_q     <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!issue_done_q) begin
						if (scan_q == LAST_SLOT) begin
							issue_done_q <= 1'b1;
						end else begin
							scan_q <= scan_q + AW'(1);
						end
					end
					if (rd_vld_s1) begin
						if (exact) begin
							result_q.kind         <= KIND_BINDING;
							result_q.binding_slot <= 7'(rd_slot_s1);
							result_q.raw_byte     <= 8'd0;
							result_q.last         <= 1'b1;
							cnt_q                 <= '0;
							state_q               <= ST_IDLE;
						end else begin
							if (prefix_now) begin
								prefix_q <= 1'b1;
							end
							if (rd_slot_s1 == LAST_SLOT) begin
								if (prefix_q || prefix_now) begin
									state_q <= ST_IDLE;
								end else begin
									emit_q  <= '0;
									state_q <= ST_EMIT;
								end
							end
						end
					end
				end
				ST_EMIT: begin
					result_q.kind         <= KIND_RAW;
					result_q.binding_slot <= 7'd0;
					result_q.raw_byte     <= gb_q[emit_q];
					result_q.last         <= emit_last;
					emit_q                <= emit_q + IW'(1);
					if (emit_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
`default_nettype wire
